/* sv/line_start_index_and_lookup_top_defines.svh */
// Assertion macros for the line start index block.
// Used by the port checker; depends on nothing else.
`ifndef LINE_START_INDEX_AND_LOOKUP_TOP_DEFINES_SVH
`define LINE_START_INDEX_AND_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define LSIL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lsil check failed");

// Next-cycle implication, reset-qualified.
`define LSIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lsil check failed");

`endif

/* sv/lsil_pkg.sv */
// Package for the line start index and lookup block.
// Types, codes and defaults shared by the RTL, interfaces and checker.
`timescale 1ns / 1ps
`default_nettype none

package lsil_pkg;

  // Default capacities
  localparam int unsigned DefMaxLines = 1024;
  localparam int unsigned DefMaxBytes = 65536;

  // Fixed payload widths
  localparam int unsigned CmdW     = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffsetW  = 17;
  localparam int unsigned LineNumW = 11;
  localparam int unsigned ColW     = 17;
  localparam int unsigned PosW     = 17;

  localparam logic [ByteW-1:0] NewlineByte = 8'd10;

  typedef enum logic [CmdW-1:0] {
    CmdAppend = 2'd0,
    CmdQuery  = 2'd1,
    CmdClear  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCmp,
    StFinish
  } state_e;

endpackage

`default_nettype wire

/* sv/lsil_if.sv */
// Valid/ready channel interfaces: request beats in, lookup result beats out.
// Depends on lsil_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsil_req_if;
  logic                          valid;
  logic                          ready;
  logic [lsil_pkg::CmdW-1:0]     command;
  logic [lsil_pkg::ByteW-1:0]    byte_value;
  logic [lsil_pkg::OffsetW-1:0]  query_offset;

  modport source (output valid, command, byte_value, query_offset, input ready);
  modport sink   (input valid, command, byte_value, query_offset, output ready);
  modport mon    (input valid, ready, command, byte_value, query_offset);
endinterface

interface lsil_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lsil_pkg::LineNumW-1:0]  line_number;
  logic [lsil_pkg::ColW-1:0]      column_number;
  logic [lsil_pkg::PosW-1:0]      clamped_position;
  logic                           overflow_seen;

  modport source (output valid, line_number, column_number, clamped_position,
                  overflow_seen, input ready);
  modport sink   (input valid, line_number, column_number, clamped_position,
                  overflow_seen, output ready);
  modport mon    (input valid, ready, line_number, column_number, clamped_position,
                  overflow_seen);
endinterface

`default_nettype wire

/* sv/line_start_index_and_lookup_top.sv */
// Top level of the line start index and lookup block.
// Depends on lsil_pkg, lsil_req_if / lsil_rsp_if and lsil_ram.
//
//   channel | dir | beat contents                                   | accepted when
//   req_i   | in  | command, byte_value, query_offset               | valid && ready
//   rsp_o   | out | line_number, column_number, clamped_position,   | valid && ready
//           |     | overflow_seen                                   |
//
// Append, clear and the unused code are each handled in StIdle; one byte per cycle
// streams in while no query is in progress. A query runs k search steps, k at most
// ceil(log2(lines recorded)); each step is one read of the line start RAM (StRead)
// followed by a compare (StCmp), and a final StRead and StFinish close the query.
// Reset clears the counters and the FSM; the RAM holds garbage until written and its
// read data is only ever used from entries written since the last clear.
// A query's result waits in the output register; further appends and clears are taken
// while it waits, and a later query stalls only in its StFinish state.
`timescale 1ns / 1ps
`default_nettype none

module line_start_index_and_lookup_top #(
  parameter int unsigned MaxLines = lsil_pkg::DefMaxLines,
  parameter int unsigned MaxBytes = lsil_pkg::DefMaxBytes
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lsil_req_if.sink   req_i,
  lsil_rsp_if.source rsp_o
);

  // Byte offsets need to hold MaxBytes itself; line counts need MaxLines itself.
  localparam int unsigned OffW  = $clog2(MaxBytes + 1);
  localparam int unsigned LineW = $clog2(MaxLines + 1);
  localparam int unsigned IdxW  = $clog2(MaxLines);

  // ---------------------------------------------------------------------------
  // Text state
  // ---------------------------------------------------------------------------
  logic [OffW-1:0]  bytes_q, bytes_d;
  logic [LineW-1:0] lines_q, lines_d;
  logic             ovf_q, ovf_d;

  // Search state
  lsil_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  lo_q, lo_d;
  logic [LineW-1:0] hi_q, hi_d;
  logic [IdxW-1:0]  mid_q, mid_d;
  logic [OffW-1:0]  clamp_q, clamp_d;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [lsil_pkg::LineNumW-1:0] out_line_q, out_line_d;
  logic [lsil_pkg::ColW-1:0]     out_col_q, out_col_d;
  logic [lsil_pkg::PosW-1:0]     out_pos_q, out_pos_d;
  logic                          out_ovf_q, out_ovf_d;

  // RAM port signals
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [OffW-1:0]  wr_data;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic [OffW-1:0]  rd_data;

  // Helpers
  logic [LineW-1:0] mid_full;
  logic [OffW-1:0]  line_start;
  logic [31:0]      line_wide;
  logic [31:0]      col_wide;
  logic             out_free;

  assign out_free = !out_valid_q || rsp_o.ready;

  // Midpoint of the live window; lo < mid < hi whenever a step runs.
  assign mid_full = LineW'(lo_q) + ((hi_q - LineW'(lo_q)) >> 1);

  // Entry 0 is never stored: line 1 always starts at offset 0.
  assign line_start = (lo_q == '0) ? '0 : rd_data;
  assign line_wide  = 32'(lo_q) + 32'd1;
  assign col_wide   = 32'(clamp_q) - 32'(line_start) + 32'd1;

  always_comb begin
    state_d     = state_q;
    bytes_d     = bytes_q;
    lines_d     = lines_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    clamp_d     = clamp_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_line_d  = out_line_q;
    out_col_d   = out_col_q;
    out_pos_d   = out_pos_q;
    out_ovf_d   = out_ovf_q;
    req_i.ready = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = lines_q[IdxW-1:0];
    wr_data     = bytes_q + OffW'(1);
    rd_en       = 1'b0;
    rd_addr     = mid_full[IdxW-1:0];

    case (state_q)
      lsil_pkg::StIdle: begin
        // ready is high in this state, so valid alone marks an accepted beat
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          case (req_i.command)
            lsil_pkg::CmdAppend: begin
              if (bytes_q == OffW'(MaxBytes)) begin
                ovf_d = 1'b1;
              end else begin
                bytes_d = bytes_q + OffW'(1);
                if (req_i.byte_value == lsil_pkg::NewlineByte) begin
                  if (lines_q == LineW'(MaxLines)) begin
                    ovf_d = 1'b1;
                  end else begin
                    // Writes only happen here, never alongside a search read.
                    wr_en   = 1'b1;
                    lines_d = lines_q + LineW'(1);
                  end
                end
              end
            end
            lsil_pkg::CmdQuery: begin
              if (32'(req_i.query_offset) > 32'(bytes_q)) begin
                clamp_d = bytes_q;
              end else begin
                clamp_d = OffW'(req_i.query_offset);
              end
              lo_d    = '0;
              hi_d    = lines_q;
              state_d = lsil_pkg::StRead;
            end
            lsil_pkg::CmdClear: begin
              bytes_d = '0;
              lines_d = LineW'(1);
              ovf_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      lsil_pkg::StRead: begin
        rd_en = 1'b1;
        if (LineW'(lo_q) + LineW'(1) < hi_q) begin
          mid_d   = mid_full[IdxW-1:0];
          state_d = lsil_pkg::StCmp;
        end else begin
          // Window closed: fetch the start of the chosen line.
          rd_addr = lo_q;
          state_d = lsil_pkg::StFinish;
        end
      end

      lsil_pkg::StCmp: begin
        if (rd_data <= clamp_q) begin
          lo_d = mid_q;
        end else begin
          hi_d = LineW'(mid_q);
        end
        state_d = lsil_pkg::StRead;
      end

      lsil_pkg::StFinish: begin
        // RAM read data holds while we wait for the output register.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_line_d  = line_wide[lsil_pkg::LineNumW-1:0];
          out_col_d   = col_wide[lsil_pkg::ColW-1:0];
          out_pos_d   = lsil_pkg::PosW'(clamp_q);
          out_ovf_d   = ovf_q;
          state_d     = lsil_pkg::StIdle;
        end
      end

      default: begin
        state_d = lsil_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsil_pkg::StIdle;
      bytes_q     <= '0;
      lines_q     <= LineW'(1);
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bytes_q     <= bytes_d;
      lines_q     <= lines_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    clamp_q    <= clamp_d;
    out_line_q <= out_line_d;
    out_col_q  <= out_col_d;
    out_pos_q  <= out_pos_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Line start table: entry n holds the start offset of line n+1.
  lsil_ram #(
    .Width (OffW),
    .Depth (MaxLines)
  ) u_lsil_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.line_number      = out_line_q;
  assign rsp_o.column_number    = out_col_q;
  assign rsp_o.clamped_position = out_pos_q;
  assign rsp_o.overflow_seen    = out_ovf_q;

endmodule

`default_nettype wire

/* sv/lsil_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lsil_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* sv/lsil_checker.sv */
// Port-level checker for line_start_index_and_lookup_top, bound to the top level.
// Depends on lsil_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "line_start_index_and_lookup_top_defines.svh"

module lsil_checker (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  lsil_req_if.sink   req_i,
  lsil_rsp_if.source rsp_o
);

  logic query_fire;
  assign query_fire = req_i.valid && req_i.ready &&
                      (req_i.command == lsil_pkg::CmdQuery);

  // A stalled result beat stays offered.
  `LSIL_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid)

  // A query occupies the block: no request taken in the following cycle.
  `LSIL_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_fire, !req_i.ready)

  // Results carry one-based line and column.
  `LSIL_ASSERT_NOW(a_one_based, clk_i, rst_ni, rsp_o.valid,
                   rsp_o.line_number != '0 && rsp_o.column_number != '0)

  // A new result only follows a busy cycle of the search.
  `LSIL_ASSERT_NOW(a_rsp_after_search, clk_i, rst_ni, $rose(rsp_o.valid), $past(!req_i.ready))

endmodule

bind line_start_index_and_lookup_top lsil_checker u_lsil_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o)
);

`default_nettype wire
